// File: hdl/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg: shared types and codes for the worst-fit block allocator
// Request modes, response status codes, controller states and the structs
// that travel between the controller and the search cells.
// ----------------------------------------------------------------------------
package wfba_pkg;

   // default configuration
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_WIDTH_DEF = 16;

   // fixed field widths of the request and response ports
   localparam int MODE_W   = 2;
   localparam int ITEM_W   = 16;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int GRANT_W  = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_ALLOC = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC   = 3'd0,
      ST_ADDED   = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_FULL    = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_HOLD = 2'd2
   } state_type;

   // broadcast commands from the controller to every cell
   typedef struct packed {
      logic clear;
      logic write_en;
      logic mark_en;
   } cell_ctrl_type;

   // flags of the search token passed from cell to cell
   typedef struct packed {
      logic valid;
      logic found;
   } token_type;

endpackage

// File: hdl/wfba_cell.sv
// ----------------------------------------------------------------------------
// wfba_cell: one slot of the block table with its stage of the search chain
// Holds one block size and its used and loaded flags, and updates the search
// token with this slot when the slot is free, fits and beats the best so far.
// ----------------------------------------------------------------------------
module wfba_cell #(
   parameter int IDX_WIDTH  = 4,
   parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wfba_pkg::cell_ctrl_type   ctrl,
   input  logic [IDX_WIDTH-1:0]      cell_idx,
   input  logic [IDX_WIDTH-1:0]      write_idx,
   input  logic [SIZE_WIDTH-1:0]     write_size,
   input  logic [IDX_WIDTH-1:0]      mark_idx,
   input  logic [SIZE_WIDTH-1:0]     req_size,
   input  wfba_pkg::token_type       tok_in,
   input  logic [IDX_WIDTH-1:0]      tok_in_idx,
   input  logic [SIZE_WIDTH-1:0]     tok_in_size,
   output wfba_pkg::token_type       tok_out,
   output logic [IDX_WIDTH-1:0]      tok_out_idx,
   output logic [SIZE_WIDTH-1:0]     tok_out_size
);

   logic [SIZE_WIDTH-1:0] size_ff;
   logic                  used_ff, used_in;
   logic                  loaded_ff, loaded_in;
   wfba_pkg::token_type   tok_ff, tok_in_nxt;
   logic [IDX_WIDTH-1:0]  tok_idx_ff, tok_idx_in;
   logic [SIZE_WIDTH-1:0] tok_size_ff, tok_size_in;
   logic                  hit_write;
   logic                  eligible;
   logic                  take;

   assign hit_write = ctrl.write_en && (write_idx == cell_idx);

   // slot flags: clear drops all, add loads a fresh free block, grant marks used
   always_comb begin
      used_in   = used_ff;
      loaded_in = loaded_ff;
      if (ctrl.clear) begin
         used_in   = 1'b0;
         loaded_in = 1'b0;
      end else if (hit_write) begin
         used_in   = 1'b0;
         loaded_in = 1'b1;
      end else if (ctrl.mark_en && (mark_idx == cell_idx)) begin
         used_in   = 1'b1;
      end
   end

   // take the token's best when this slot is a strictly larger fit
   assign eligible = loaded_ff && !used_ff && (size_ff >= req_size);
   assign take     = tok_in.valid && eligible && (!tok_in.found || (size_ff > tok_in_size));

   always_comb begin
      tok_in_nxt.valid = tok_in.valid;
      tok_in_nxt.found = tok_in.found || take;
      tok_idx_in       = take ? cell_idx : tok_in_idx;
      tok_size_in      = take ? size_ff : tok_in_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         loaded_ff <= 1'b0;
         tok_ff    <= '0;
      end else begin
         used_ff   <= used_in;
         loaded_ff <= loaded_in;
         tok_ff    <= tok_in_nxt;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (hit_write) begin
         size_ff <= write_size;
      end
      tok_idx_ff  <= tok_idx_in;
      tok_size_ff <= tok_size_in;
   end

   assign tok_out      = tok_ff;
   assign tok_out_idx  = tok_idx_ff;
   assign tok_out_size = tok_size_ff;

endmodule

// File: hdl/worst_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator: worst-fit fixed-partition block allocator
// Keeps a table of memory blocks in a chain of cells and grants the largest
// free block that fits each allocation request.
// ----------------------------------------------------------------------------
// A clear or add request needs no search: its response is loaded into the
// output register at the edge that accepts it, or is parked when that
// register is full and stalled. For an allocation request the request size
// is latched, then a search token walks the cell chain one cell per cycle,
// and the winning slot is marked used when the token leaves the last cell.
// The block takes no new request while a search runs or while a finished
// response waits behind a stalled output register that is already full.
// Mode three is dropped with no response. No clearing pass follows reset; the table is empty at once.
module worst_fit_block_allocator #(
   parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [wfba_pkg::MODE_W-1:0]    req_mode,
   input  logic [wfba_pkg::ITEM_W-1:0]    req_item_size,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wfba_pkg::STATUS_W-1:0]  rsp_status,
   output logic [wfba_pkg::INDEX_W-1:0]   rsp_block_index,
   output logic [wfba_pkg::GRANT_W-1:0]   rsp_granted_size
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   wfba_pkg::state_type     state_ff, state_in;
   wfba_pkg::cell_ctrl_type ctrl;
   logic                    accept;
   logic                    out_free;
   logic                    scan_done;
   logic                    start_ff, start_in;
   logic                    table_full;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SIZE_WIDTH-1:0]   req_size_ff;
   logic [31:0]             item_wide;
   logic [SIZE_WIDTH-1:0]   item_size_cut;
   logic [7:0]              count_wide;
   logic [7:0]              best_idx_wide;
   logic [31:0]             best_size_wide;

   // response being produced this cycle
   logic                              res_valid;
   wfba_pkg::status_type              res_status;
   logic [wfba_pkg::INDEX_W-1:0]      res_index;
   logic [wfba_pkg::GRANT_W-1:0]      res_size;

   // response parked while the output register is full and stalled
   wfba_pkg::status_type              pend_status_ff;
   logic [wfba_pkg::INDEX_W-1:0]      pend_index_ff;
   logic [wfba_pkg::GRANT_W-1:0]      pend_size_ff;

   logic                              rsp_valid_ff;
   wfba_pkg::status_type              rsp_status_ff;
   logic [wfba_pkg::INDEX_W-1:0]      rsp_index_ff;
   logic [wfba_pkg::GRANT_W-1:0]      rsp_size_ff;

   // search chain wiring
   wfba_pkg::token_type   tok      [0:MAX_BLOCKS];
   logic [IDX_W-1:0]      tok_idx  [0:MAX_BLOCKS];
   logic [SIZE_WIDTH-1:0] tok_size [0:MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] tok_valid_vec;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = tok[MAX_BLOCKS].valid;
   assign table_full = (count_ff == CNT_W'(MAX_BLOCKS));

   // fit field widths to the internal widths
   assign item_wide      = 32'(req_item_size);
   assign item_size_cut  = item_wide[SIZE_WIDTH-1:0];
   assign count_wide     = 8'(count_ff);
   assign best_idx_wide  = 8'(tok_idx[MAX_BLOCKS]);
   assign best_size_wide = 32'(tok_size[MAX_BLOCKS]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wfba_pkg::S_IDLE: begin
            if (accept) begin
               if (req_mode == wfba_pkg::MODE_ALLOC) begin
                  state_in = wfba_pkg::S_SCAN;
               end else if (req_mode inside {wfba_pkg::MODE_CLEAR, wfba_pkg::MODE_ADD} &&
                            !out_free) begin
                  state_in = wfba_pkg::S_HOLD;
               end
            end
         end
         wfba_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = out_free ? wfba_pkg::S_IDLE : wfba_pkg::S_HOLD;
            end
         end
         wfba_pkg::S_HOLD: begin
            if (out_free) begin
               state_in = wfba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wfba_pkg::S_IDLE;
         end
      endcase
   end

   // controller outputs: cell commands and the response of this cycle
   always_comb begin
      req_stall  = (state_ff != wfba_pkg::S_IDLE);
      ctrl       = '0;
      start_in   = 1'b0;
      res_valid  = 1'b0;
      res_status = wfba_pkg::ST_CLEARED;
      res_index  = '0;
      res_size   = '0;
      case (state_ff)
         wfba_pkg::S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  wfba_pkg::MODE_CLEAR: begin
                     ctrl.clear = 1'b1;
                     res_valid  = 1'b1;
                     res_status = wfba_pkg::ST_CLEARED;
                  end
                  wfba_pkg::MODE_ADD: begin
                     res_valid = 1'b1;
                     if (table_full) begin
                        res_status = wfba_pkg::ST_FULL;
                     end else begin
                        ctrl.write_en = 1'b1;
                        res_status    = wfba_pkg::ST_ADDED;
                        res_index     = count_wide[wfba_pkg::INDEX_W-1:0];
                     end
                  end
                  wfba_pkg::MODE_ALLOC: begin
                     start_in = 1'b1;
                  end
                  default: begin
                     res_valid = 1'b0;
                  end
               endcase
            end
         end
         wfba_pkg::S_SCAN: begin
            if (scan_done) begin
               res_valid = 1'b1;
               if (tok[MAX_BLOCKS].found) begin
                  ctrl.mark_en = 1'b1;
                  res_status   = wfba_pkg::ST_ALLOC;
                  res_index    = best_idx_wide[wfba_pkg::INDEX_W-1:0];
                  res_size     = best_size_wide[wfba_pkg::GRANT_W-1:0];
               end else begin
                  res_status = wfba_pkg::ST_NOFIT;
               end
            end
         end
         wfba_pkg::S_HOLD: begin
            res_valid = 1'b0;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // advance the fill count
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.write_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wfba_pkg::S_IDLE;
         count_ff <= '0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         start_ff <= start_in;
      end
   end

   // latch the request size for the search
   always_ff @(posedge clock) begin
      if (accept) begin
         req_size_ff <= item_size_cut;
      end
   end

   // park a response that cannot enter the output register yet
   always_ff @(posedge clock) begin
      if (res_valid && !out_free) begin
         pend_status_ff <= res_status;
         pend_index_ff  <= res_index;
         pend_size_ff   <= res_size;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid || (state_ff == wfba_pkg::S_HOLD);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (state_ff == wfba_pkg::S_HOLD) begin
            rsp_status_ff <= pend_status_ff;
            rsp_index_ff  <= pend_index_ff;
            rsp_size_ff   <= pend_size_ff;
         end else if (res_valid) begin
            rsp_status_ff <= res_status;
            rsp_index_ff  <= res_index;
            rsp_size_ff   <= res_size;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_index  = rsp_index_ff;
   assign rsp_granted_size = rsp_size_ff;

   // inject a fresh token at the head of the chain
   assign tok[0].valid = start_ff;
   assign tok[0].found = 1'b0;
   assign tok_idx[0]   = '0;
   assign tok_size[0]  = '0;

   // chain of table cells
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      wfba_cell #(
         .IDX_WIDTH  (IDX_W),
         .SIZE_WIDTH (SIZE_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .cell_idx     (IDX_W'(g)),
         .write_idx    (count_ff[IDX_W-1:0]),
         .write_size   (item_size_cut),
         .mark_idx     (tok_idx[MAX_BLOCKS]),
         .req_size     (req_size_ff),
         .tok_in       (tok[g]),
         .tok_in_idx   (tok_idx[g]),
         .tok_in_size  (tok_size[g]),
         .tok_out      (tok[g+1]),
         .tok_out_idx  (tok_idx[g+1]),
         .tok_out_size (tok_size[g+1])
      );
      assign tok_valid_vec[g] = tok[g+1].valid;
   end

`ifndef SYNTHESIS
   // at most one search token is in flight
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one search token in the chain");

   // the fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count exceeds table depth");

   // a token leaves the chain only while a search is running
   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> (state_ff == wfba_pkg::S_SCAN))
      else $error("search finished outside a scan");

   // a started search ends exactly when the token clears the chain
   a_scan_length: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> ##MAX_BLOCKS scan_done)
      else $error("search token did not arrive on time");
`endif

endmodule
